// File: hdl/pne_pkg.sv
package pne_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int OFS_W         = 24;
	localparam int OUT_W         = 18;
	localparam int IDX_W         = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_NOISE = 2'd1,
		MODE_FLAT  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_X_OFS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_OFS = 2'd2;

	localparam logic signed [OUT_W-1:0] NOISE_MAX = 18'sh1FFFF;
	localparam logic signed [OUT_W-1:0] NOISE_MIN = 18'sh20000;

	// One queued item: a table load or a sample point with offsets applied.
	typedef struct packed {
		logic               ld;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] sz;
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   val;
	} pne_item_t;

endpackage

// File: hdl/pne_perm_ram.sv
module pne_perm_ram import pne_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr0,
	input  logic [IDX_W-1:0] raddr1,
	output logic [IDX_W-1:0] rdata0,
	output logic [IDX_W-1:0] rdata1
);

	logic [IDX_W-1:0] mem [PERM_DEPTH];
	logic [IDX_W-1:0] rd0_q;
	logic [IDX_W-1:0] rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd0_q <= mem[raddr0];
			rd1_q <= mem[raddr1];
		end
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

// File: hdl/pne_fade.sv
module pne_fade import pne_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FRAC_BITS:0]   fade
);

	localparam int F  = FRAC_BITS;
	localparam int QW = F + 5;

	logic [2*F-1:0] p_s1;
	logic [F-1:0]   t_s1;
	logic [2*F-1:0] c_s2;
	logic [F+3:0]   q_s2;
	logic [2*F+3:0] m_s3;
	logic [F:0]     fade_s4;
	logic [2*F+2:0] p6;
	logic [QW-1:0]  q_full;

	// q = 10 + 6t^2 - 15t, computed from the full-precision square.
	always_comb begin
		p6     = (2*F+3)'({p_s1, 2'b00}) + (2*F+3)'({p_s1, 1'b0});
		q_full = (QW'(10) << F) + QW'(p6[2*F+2:F])
			- ((QW'(t_s1) << 4) - QW'(t_s1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= t * t;
			t_s1    <= t;
			c_s2    <= p_s1[2*F-1:F] * t_s1;
			q_s2    <= q_full[F+3:0];
			m_s3    <= c_s2[2*F-1:F] * q_s2;
			fade_s4 <= m_s3[2*F:F];
		end
	end

	assign fade = fade_s4;

endmodule

// File: hdl/pne_front.sv
module pne_front import pne_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [COORD_W-1:0]   coord_x,
	input  logic [COORD_W-1:0]   coord_y,
	input  logic [COORD_W-1:0]   coord_z,
	input  logic [IDX_W-1:0]     table_index,
	input  logic [IDX_W-1:0]     table_value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OFS_W-1:0]     cfg_data,
	output pne_item_t            item,
	output logic                 item_valid,
	input  logic                 item_pop
);

	logic [OFS_W-1:0] x_ofs_q;
	logic [OFS_W-1:0] y_ofs_q;
	logic [OFS_W-1:0] z_ofs_q;
	pne_item_t        queue_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	pne_item_t        new_item;
	logic             push;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (count_q != 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = queue_q[rd_ptr_q];
	// The unused mode code is dropped here and never reaches the back end.
	assign push = in_valid && in_ready && (mode != MODE_NONE);

	always_comb begin
		new_item.ld  = (mode == MODE_LOAD);
		new_item.sx  = coord_x + COORD_W'(x_ofs_q);
		new_item.sy  = (mode == MODE_NOISE) ? coord_y + COORD_W'(y_ofs_q) : '0;
		new_item.sz  = coord_z + COORD_W'(z_ofs_q);
		new_item.idx = table_index;
		new_item.val = table_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_ofs_q <= '0;
			y_ofs_q <= '0;
			z_ofs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_OFS: x_ofs_q <= cfg_data;
				REG_Y_OFS: y_ofs_q <= cfg_data;
				REG_Z_OFS: z_ofs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(item_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// File: hdl/pne_back.sv
module pne_back import pne_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pne_item_t               item,
	input  logic                    item_valid,
	output logic                    item_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] noise_value
);

	localparam int F    = FRAC_BITS;
	localparam int GW   = F + 4;
	localparam int PW   = 2*F + 7;
	localparam int RW   = GW + 8;
	localparam int DOWN = (F >= 16) ? F - 16 : 0;
	localparam int UP   = (F < 16) ? 16 - F : 0;
	localparam logic signed [GW-1:0] ONE    = GW'(1) <<< F;
	localparam logic signed [RW-1:0] SAT_HI = RW'(NOISE_MAX);
	localparam logic signed [RW-1:0] SAT_LO = RW'(NOISE_MIN);

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
		input logic signed [GW-1:0] z);
		logic signed [GW-1:0] p;
		logic signed [GW-1:0] q;
		p = (h < 4'd8) ? x : y;
		if (h < 4'd4) begin
			q = y;
		end else if (h == 4'd12 || h == 4'd14) begin
			q = x;
		end else begin
			q = z;
		end
		return (h[0] ? -p : p) + (h[1] ? -q : q);
	endfunction

	function automatic logic signed [PW-1:0] lmul(input logic [F:0] t,
		input logic signed [GW-1:0] a, input logic signed [GW-1:0] b);
		logic signed [GW:0] diff;
		diff = {b[GW-1], b} - {a[GW-1], a};
		return $signed({1'b0, t}) * diff;
	endfunction

	function automatic logic signed [GW-1:0] lres(input logic signed [GW-1:0] a,
		input logic signed [PW-1:0] prod);
		logic signed [PW-1:0] sh;
		sh = prod >>> F;
		return a + $signed(sh[GW-1:0]);
	endfunction

	logic en;

	logic [IDX_W-1:0] cx0, cx1;
	logic [IDX_W-1:0] ta0, ta1;
	logic [IDX_W-1:0] hx0, hx1;
	logic [IDX_W-1:0] tb [2][2];
	logic [IDX_W-1:0] hc [4];
	logic [IDX_W-1:0] hash [4][2];

	logic             v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
	logic             ld1_s1, ld2_s2;
	logic [IDX_W-1:0] idx_s1, val_s1, idx_s2, val_s2;
	logic [IDX_W-1:0] cy_s1, cz_s1, cz_s2;
	logic [F-1:0]     fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3;

	logic [F:0] fade_u, fade_v, fade_w;
	logic [F:0] v_s5, w_s5, w_s6;

	logic signed [GW-1:0] g_s4 [8];
	logic signed [GW-1:0] base_s5 [4];
	logic signed [PW-1:0] prod_s5 [4];
	logic signed [GW-1:0] base_s6 [2];
	logic signed [PW-1:0] prod_s6 [2];
	logic signed [GW-1:0] base_s7;
	logic signed [PW-1:0] prod_s7;

	logic signed [GW-1:0] xs [2], ys [2], zs [2];
	logic signed [GW-1:0] ax [4];
	logic signed [GW-1:0] ay [2];
	logic signed [GW-1:0] r;
	logic signed [RW-1:0] r_sc;
	logic signed [OUT_W-1:0] sat;

	logic                    out_vld_q;
	logic signed [OUT_W-1:0] noise_q;

	// The whole back end moves as one; it only holds while a result waits.
	assign en       = !out_vld_q || out_ready;
	assign item_pop = en && item_valid;

	assign cx0 = item.sx[F +: IDX_W];
	assign cx1 = cx0 + 1'b1;

	pne_perm_ram u_ram_a (
		.clk    (clk),
		.we     (item_pop && item.ld),
		.waddr  (item.idx),
		.wdata  (item.val),
		.re     (en),
		.raddr0 (cx0),
		.raddr1 (cx1),
		.rdata0 (ta0),
		.rdata1 (ta1)
	);

	pne_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(en), .t(item.sx[F-1:0]), .fade(fade_u));
	pne_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(en), .t(item.sy[F-1:0]), .fade(fade_v));
	pne_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(en), .t(item.sz[F-1:0]), .fade(fade_w));

	assign hx0 = ta0 + cy_s1;
	assign hx1 = ta1 + cy_s1;

	pne_perm_ram u_ram_b0 (
		.clk    (clk),
		.we     (en && v1_q && ld1_s1),
		.waddr  (idx_s1),
		.wdata  (val_s1),
		.re     (en),
		.raddr0 (hx0),
		.raddr1 (hx0 + 1'b1),
		.rdata0 (tb[0][0]),
		.rdata1 (tb[0][1])
	);

	pne_perm_ram u_ram_b1 (
		.clk    (clk),
		.we     (en && v1_q && ld1_s1),
		.waddr  (idx_s1),
		.wdata  (val_s1),
		.re     (en),
		.raddr0 (hx1),
		.raddr1 (hx1 + 1'b1),
		.rdata0 (tb[1][0]),
		.rdata1 (tb[1][1])
	);

	// Corner hash j = {y, x}: x picks the second-level copy, y its port.
	for (genvar j = 0; j < 4; j++) begin : g_ram_c
		assign hc[j] = tb[j % 2][j / 2] + cz_s2;

		pne_perm_ram u_ram_c (
			.clk    (clk),
			.we     (en && v2_q && ld2_s2),
			.waddr  (idx_s2),
			.wdata  (val_s2),
			.re     (en),
			.raddr0 (hc[j]),
			.raddr1 (hc[j] + 1'b1),
			.rdata0 (hash[j][0]),
			.rdata1 (hash[j][1])
		);
	end

	always_comb begin
		xs[0] = $signed(GW'(fx_s3));
		xs[1] = $signed(GW'(fx_s3)) - ONE;
		ys[0] = $signed(GW'(fy_s3));
		ys[1] = $signed(GW'(fy_s3)) - ONE;
		zs[0] = $signed(GW'(fz_s3));
		zs[1] = $signed(GW'(fz_s3)) - ONE;
		for (int j = 0; j < 4; j++) begin
			ax[j] = lres(base_s5[j], prod_s5[j]);
		end
		for (int j = 0; j < 2; j++) begin
			ay[j] = lres(base_s6[j], prod_s6[j]);
		end
		r    = lres(base_s7, prod_s7);
		r_sc = (RW'(r) >>> DOWN) <<< UP;
		if (r_sc > SAT_HI) begin
			sat = NOISE_MAX;
		end else if (r_sc < SAT_LO) begin
			sat = NOISE_MIN;
		end else begin
			sat = r_sc[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			v4_q      <= 1'b0;
			v5_q      <= 1'b0;
			v6_q      <= 1'b0;
			v7_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v1_q      <= item_valid;
			v2_q      <= v1_q;
			v3_q      <= v2_q && !ld2_s2;
			v4_q      <= v3_q;
			v5_q      <= v4_q;
			v6_q      <= v5_q;
			v7_q      <= v6_q;
			out_vld_q <= v7_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld1_s1 <= item.ld;
			idx_s1 <= item.idx;
			val_s1 <= item.val;
			cy_s1  <= item.sy[F +: IDX_W];
			cz_s1  <= item.sz[F +: IDX_W];
			fx_s1  <= item.sx[F-1:0];
			fy_s1  <= item.sy[F-1:0];
			fz_s1  <= item.sz[F-1:0];

			ld2_s2 <= ld1_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			cz_s2  <= cz_s1;
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			fz_s2  <= fz_s1;

			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;

			// Corner k = {z, y, x}.
			for (int k = 0; k < 8; k++) begin
				g_s4[k] <= grad(hash[k % 4][k / 4][3:0], xs[k % 2], ys[(k / 2) % 2],
					zs[k / 4]);
			end

			for (int j = 0; j < 4; j++) begin
				base_s5[j] <= g_s4[2*j];
				prod_s5[j] <= lmul(fade_u, g_s4[2*j], g_s4[2*j+1]);
			end
			v_s5 <= fade_v;
			w_s5 <= fade_w;

			for (int j = 0; j < 2; j++) begin
				base_s6[j] <= ax[2*j];
				prod_s6[j] <= lmul(v_s5, ax[2*j], ax[2*j+1]);
			end
			w_s6 <= w_s5;

			base_s7 <= ay[0];
			prod_s7 <= lmul(w_s6, ay[0], ay[1]);

			noise_q <= sat;
		end
	end

	assign out_valid   = out_vld_q;
	assign noise_value = noise_q;

endmodule

// File: hdl/perlin_noise_eval.sv
// An accepted beat is written into the front queue, then passes through the
// back-end stages, the last of which loads the output register.
// Throughput: one beat per cycle; the back end stalls as a whole only while a
// result waits on the output, and the two-entry queue decouples the input side.
// Reset clears the offsets, the queue and all valid flags; the permutation
// table copies are not cleared and must be loaded before use.
module perlin_noise_eval import pne_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic [IDX_W-1:0]        table_index,
	input  logic [IDX_W-1:0]        table_value,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [OFS_W-1:0]        cfg_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] noise_value
);

	pne_item_t item;
	logic      item_valid;
	logic      item_pop;

	pne_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.table_index (table_index),
		.table_value (table_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop)
	);

	pne_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.noise_value (noise_value)
	);

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import pne_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 14;

	typedef struct {
		mode_t       m;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [7:0]  ti;
		logic [7:0]  tv;
	} sample_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [IDX_W-1:0] table_index;
	logic [IDX_W-1:0] table_value;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [OFS_W-1:0] cfg_data;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] noise_value;

	sample_t pending_samples[$];
	logic signed [OUT_W-1:0] expected_noise[$];
	logic [7:0] perm_copy[PERM_DEPTH];
	logic [31:0] ofs_x, ofs_y, ofs_z;
	int errors;
	int cycles;
	int burst_left;
	int gap_left;
	int stall_style;
	int stall_cnt;

	perlin_noise_eval i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.table_index(table_index),
		.table_value(table_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.noise_value(noise_value)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint fade(longint unsigned t);
		longint unsigned q, c;
		q = 10 * ONE + ((6 * t * t) >> FB) - 15 * t;
		c = (t * t) >> FB;
		c = (c * t) >> FB;
		return longint'((c * q) >> FB);
	endfunction

	function automatic longint blend(longint t, longint a, longint b);
		return a + ((t * (b - a)) >>> FB);
	endfunction

	function automatic longint corner_grad(int hash, longint x, longint y, longint z);
		int h;
		longint p, q;
		h = hash & 15;
		p = (h < 8) ? x : y;
		q = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return ((h & 1) ? -p : p) + ((h & 2) ? -q : q);
	endfunction

	function automatic int perm(int i);
		return int'(perm_copy[i & 255]);
	endfunction

	// Noise at one sample point, with the current offsets applied.
	function automatic logic signed [OUT_W-1:0] noise_at(sample_t s);
		logic [31:0] sx, sy, sz;
		int cx, cy, cz, hx0, hx1, h00, h01, h10, h11;
		longint fx, fy, fz, u, v, w, r, a, b, c, d;
		sx = s.x + ofs_x;
		sz = s.z + ofs_z;
		sy = (s.m == MODE_NOISE) ? s.y + ofs_y : 32'd0;
		cx = int'((sx >> FB) & 32'hFF);
		cy = int'((sy >> FB) & 32'hFF);
		cz = int'((sz >> FB) & 32'hFF);
		fx = longint'(sx & (ONE - 1));
		fy = longint'(sy & (ONE - 1));
		fz = longint'(sz & (ONE - 1));
		u = fade(fx);
		v = fade(fy);
		w = fade(fz);
		hx0 = perm(cx) + cy;
		hx1 = perm(cx + 1) + cy;
		h00 = perm(hx0) + cz;
		h10 = perm(hx1) + cz;
		if (s.m == MODE_FLAT) begin
			a = blend(u, corner_grad(perm(h00), fx, 0, fz),
				corner_grad(perm(h10), fx - ONE, 0, fz));
			c = blend(u, corner_grad(perm(h00 + 1), fx, 0, fz - ONE),
				corner_grad(perm(h10 + 1), fx - ONE, 0, fz - ONE));
			r = blend(w, a, c);
		end else begin
			h01 = perm(hx0 + 1) + cz;
			h11 = perm(hx1 + 1) + cz;
			a = blend(u, corner_grad(perm(h00), fx, fy, fz),
				corner_grad(perm(h10), fx - ONE, fy, fz));
			b = blend(u, corner_grad(perm(h01), fx, fy - ONE, fz),
				corner_grad(perm(h11), fx - ONE, fy - ONE, fz));
			c = blend(u, corner_grad(perm(h00 + 1), fx, fy, fz - ONE),
				corner_grad(perm(h10 + 1), fx - ONE, fy, fz - ONE));
			d = blend(u, corner_grad(perm(h01 + 1), fx, fy - ONE, fz - ONE),
				corner_grad(perm(h11 + 1), fx - ONE, fy - ONE, fz - ONE));
			r = blend(w, blend(v, a, b), blend(v, c, d));
		end
		r = r >>> (FB - 16);
		if (r > 131071)
			r = 131071;
		if (r < -131072)
			r = -131072;
		return r[OUT_W-1:0];
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		sample_t cur;
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				cur.m = mode_t'(mode);
				cur.x = coord_x;
				cur.y = coord_y;
				cur.z = coord_z;
				cur.ti = table_index;
				cur.tv = table_value;
				if (cur.m == MODE_LOAD)
					perm_copy[cur.ti] = cur.tv;
				else if (cur.m != MODE_NONE)
					expected_noise.push_back(noise_at(cur));
			end
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_samples.size() > 0) begin
				s = pending_samples.pop_front();
				mode <= s.m;
				coord_x <= s.x;
				coord_y <= s.y;
				coord_z <= s.z;
				table_index <= s.ti;
				table_value <= s.tv;
				nv = 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
			in_valid <= nv;
		end
	end

	// Receiver stall pattern switches periodically to a randomly chosen style.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_style <= 0;
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 300 == 299)
				stall_style <= $urandom_range(0, 3);
			case (stall_style)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_cnt % 4 == 0);
			default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_noise.size() == 0) begin
				$display("%0t: unexpected result noise_value=%0d", $time, noise_value);
				errors++;
			end else begin
				want = expected_noise.pop_front();
				if (noise_value !== want) begin
					$display("%0t: noise_value mismatch, expected %0d actual %0d",
						$time, want, noise_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_X_OFS: ofs_x = {8'd0, d};
		REG_Y_OFS: ofs_y = {8'd0, d};
		default: ofs_z = {8'd0, d};
		endcase
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_noise.size() > 0);
		// Table loads give no result, so let any of them finish as well.
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic sample_t point(mode_t m, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		sample_t s;
		s.m = m;
		s.x = x;
		s.y = y;
		s.z = z;
		s.ti = 8'($urandom);
		s.tv = 8'($urandom);
		return s;
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 9) < 6)
			return $urandom;
		return $urandom_range(0, 32'h0007FFFF) - 32'h00040000;
	endfunction

	task automatic add_random(int n);
		sample_t s;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			s = point(MODE_NOISE, rand_coord(), rand_coord(), rand_coord());
			if (k < 10)
				s.m = MODE_LOAD;
			else if (k < 13)
				s.m = MODE_NONE;
			else if (k < 50)
				s.m = MODE_FLAT;
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		sample_t s;
		logic [7:0] shuffled[PERM_DEPTH];
		int j;
		logic [7:0] t;
		logic [OFS_W-1:0] settings[6][3];
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_NONE;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		table_index = '0;
		table_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_X_OFS;
		cfg_data = '0;
		out_ready = 1'b0;
		ofs_x = 0;
		ofs_y = 0;
		ofs_z = 0;
		errors = 0;
		cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Fill every table entry with a random permutation before any lookup.
		for (int i = 0; i < PERM_DEPTH; i++)
			shuffled[i] = 8'(i);
		for (int i = PERM_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = shuffled[i];
			shuffled[i] = shuffled[j];
			shuffled[j] = t;
		end
		for (int i = 0; i < PERM_DEPTH; i++) begin
			s = point(MODE_LOAD, $urandom, $urandom, $urandom);
			s.ti = 8'(i);
			s.tv = shuffled[i];
			pending_samples.push_back(s);
		end

		// Directed points: coordinate extremes, cell borders, both noise modes,
		// the unused mode and a reload that is then looked up.
		pending_samples.push_back(point(MODE_NOISE, 0, 0, 0));
		pending_samples.push_back(point(MODE_FLAT, 0, 32'h12345678, 0));
		pending_samples.push_back(point(MODE_NOISE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		pending_samples.push_back(point(MODE_NOISE, 32'h80000000, 32'h80000000, 32'h80000000));
		pending_samples.push_back(point(MODE_NOISE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		pending_samples.push_back(point(MODE_FLAT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000));
		pending_samples.push_back(point(MODE_FLAT, 32'h7FFFFFFF, 0, 32'hFFFFFFFF));
		pending_samples.push_back(point(MODE_NOISE, 32'h0000FFFF, 32'h00010000, 32'h0000FFFF));
		pending_samples.push_back(point(MODE_NOISE, 32'h00008000, 32'h00008000, 32'h00008000));
		pending_samples.push_back(point(MODE_FLAT, 32'h00FF8000, 0, 32'h00FF8000));
		pending_samples.push_back(point(MODE_NONE, 32'h00018000, 0, 0));
		s = point(MODE_LOAD, 0, 0, 0);
		s.ti = 8'd0;
		s.tv = 8'd255;
		pending_samples.push_back(s);
		pending_samples.push_back(point(MODE_NOISE, 32'h00004000, 32'h0000C000, 32'h00002000));
		pending_samples.push_back(point(MODE_FLAT, 32'h00004000, 0, 32'h0000C000));
		add_random(280);
		drain();

		settings[0] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		settings[1] = '{24'h000000, 24'hFFFFFF, 24'h000000};
		settings[2] = '{24'h008000, 24'h000001, 24'hFF0000};
		settings[3] = '{OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom)};
		settings[4] = '{OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom)};
		settings[5] = '{24'h000000, 24'h000000, 24'h000000};
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_X_OFS, settings[p][0]);
			write_reg(REG_Y_OFS, settings[p][1]);
			write_reg(REG_Z_OFS, settings[p][2]);
			add_random(230);
			drain();
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
